// ----- rtl/dqis_pkg.sv -----
package dqis_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_READ       = 2'd2,
        MODE_FIND       = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_MISS  = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

endpackage

// ----- rtl/dqis_in_if.sv -----
interface dqis_in_if;
    import dqis_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [MODE_W-1:0]   mode;
    logic signed [VALUE_W-1:0]  value;
    logic        [POS_W-1:0]    position;

    modport source (output valid, output mode, output value, output position, input ready);
    modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

// ----- rtl/dqis_out_if.sv -----
interface dqis_out_if;
    import dqis_pkg::*;

    logic                       valid;
    logic                       ready;
    logic        [STATUS_W-1:0] status;
    logic signed [VALUE_W-1:0]  data_out;

    modport source (output valid, output status, output data_out, input ready);
    modport sink   (input valid, input status, input data_out, output ready);
endinterface

// ----- rtl/dqis_mem.sv -----
module dqis_mem #(
    parameter int DEPTH = dqis_pkg::DEPTH_DEF,
    parameter int AW    = 4
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic signed [dqis_pkg::VALUE_W-1:0] i_wdata,
    input  logic                               i_re,
    input  logic [AW-1:0]                      i_raddr,
    output logic signed [dqis_pkg::VALUE_W-1:0] o_rdata
);
    import dqis_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/dqis_oreg.sv -----
module dqis_oreg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  dqis_pkg::t_status                   i_status,
    input  logic signed [dqis_pkg::VALUE_W-1:0] i_data,
    output logic                                o_room,
    dqis_out_if.source                          o_out
);
    import dqis_pkg::*;

    // two-word output queue; head drives the port
    logic [1:0]                r_cnt;
    t_status                   r_st  [2];
    logic signed [VALUE_W-1:0] r_dat [2];
    logic                      w_pop;
    logic                      w_wsel;
    logic [1:0]                w_level;

    assign w_pop   = o_out.valid && o_out.ready;
    assign w_level = r_cnt - {1'b0, w_pop};
    assign w_wsel  = (w_level == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= w_level + {1'b0, i_push};
        end
    end

    // a new word into an emptied head takes priority over the shift
    always_ff @(posedge i_clk) begin
        if (i_push && !w_wsel) begin
            r_st[0]  <= i_status;
            r_dat[0] <= i_data;
        end else if (w_pop) begin
            r_st[0]  <= r_st[1];
            r_dat[0] <= r_dat[1];
        end
        if (i_push && w_wsel) begin
            r_st[1]  <= i_status;
            r_dat[1] <= i_data;
        end
    end

    assign o_room         = (r_cnt < 2'd2);
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.status   = r_st[0];
    assign o_out.data_out = r_dat[0];

endmodule

// ----- rtl/deque_with_index_read_and_search_top.sv -----
// Flow: a push goes straight to the output queue, a read by position makes one memory
// read, and a find scans from the front, one stored word compared per cycle.
// Throughput: one word at a time; a new word every cycle for pushes, while reads and
// finds hold the input until their result is pushed; a full output queue also stalls the input.
// Reset: synchronous, active low; clears front pointer, count, sequencer and output
// queue. Entry memory is not cleared; only live slots are ever read.
module deque_with_index_read_and_search_top #(
    parameter int DEPTH = dqis_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dqis_in_if.sink    i_in,
    dqis_out_if.source o_out
);
    import dqis_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;  // slot index width
    localparam int CW = $clog2(DEPTH + 1);                 // count, 0..DEPTH
    localparam int PW = (CW > POS_W) ? CW : POS_W;         // position compare width

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,   // waiting for a word; pushes finish here
        S_READ = 3'b010,   // read data for a position lookup comes back
        S_SCAN = 3'b100    // one stored entry compared per cycle
    } t_state;

    t_state                    r_state, n_state;
    logic [AW-1:0]             r_front, n_front;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_idx,   n_idx;     // scan offset from front
    logic [AW-1:0]             r_slot,  n_slot;    // slot being compared
    logic signed [VALUE_W-1:0] r_key,   n_key;     // search value

    // entry memory port
    logic                      w_we, w_re;
    logic [AW-1:0]             w_waddr, w_raddr;
    logic signed [VALUE_W-1:0] w_rdata;

    // towards the output queue
    logic                      w_room, w_push;
    t_status                   w_status;
    logic signed [VALUE_W-1:0] w_data;

    logic                      w_accept;
    logic                      w_full, w_empty;
    logic [AW-1:0]             w_front_dec, w_back_slot, w_read_slot, w_slot_inc;
    logic [AW:0]               w_back_sum, w_read_sum;

    assign i_in.ready = (r_state == S_IDLE) && w_room;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // ring arithmetic: front + offset with offset < DEPTH, so one subtract wraps it
    assign w_front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - 1'b1;
    assign w_back_sum  = {1'b0, r_front} + {1'b0, r_count[AW-1:0]};
    assign w_back_slot = (w_back_sum >= (AW+1)'(DEPTH)) ?
                         AW'(w_back_sum - (AW+1)'(DEPTH)) : w_back_sum[AW-1:0];
    assign w_read_sum  = {1'b0, r_front} + (AW+1)'(i_in.position);
    assign w_read_slot = (w_read_sum >= (AW+1)'(DEPTH)) ?
                         AW'(w_read_sum - (AW+1)'(DEPTH)) : w_read_sum[AW-1:0];
    assign w_slot_inc  = (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + 1'b1;

    // Writes only happen on a push in S_IDLE and reads are issued from the next
    // cycle on, so a read never meets a write to the same slot in flight.
    always_comb begin
        n_state  = r_state;
        n_front  = r_front;
        n_count  = r_count;
        n_idx    = r_idx;
        n_slot   = r_slot;
        n_key    = r_key;
        w_we     = 1'b0;
        w_waddr  = w_front_dec;
        w_re     = 1'b0;
        w_raddr  = w_slot_inc;
        w_push   = 1'b0;
        w_status = ST_OK;
        w_data   = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_mode'(i_in.mode))
                        MODE_PUSH_FRONT: begin
                            w_push = 1'b1;
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_front_dec;
                                n_front = w_front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_PUSH_BACK: begin
                            w_push = 1'b1;
                            if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = w_back_slot;
                                n_count = r_count + 1'b1;
                            end
                        end
                        MODE_READ: begin
                            if (w_empty) begin
                                w_push   = 1'b1;
                                w_status = ST_EMPTY;
                            end else if (PW'(i_in.position) >= PW'(r_count)) begin
                                w_push   = 1'b1;
                                w_status = ST_MISS;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = w_read_slot;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            // find: scan from the front
                            if (w_empty) begin
                                w_push   = 1'b1;
                                w_status = ST_EMPTY;
                            end else begin
                                w_re    = 1'b1;
                                w_raddr = r_front;
                                n_slot  = r_front;
                                n_idx   = '0;
                                n_key   = i_in.value;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                w_push   = 1'b1;
                w_data   = w_rdata;
                n_state  = S_IDLE;
            end
            S_SCAN: begin
                if (w_rdata == r_key) begin
                    w_push  = 1'b1;
                    w_data  = r_key;
                    n_state = S_IDLE;
                end else if (r_idx == r_count - 1'b1) begin
                    w_push   = 1'b1;
                    w_status = ST_MISS;
                    n_state  = S_IDLE;
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_slot_inc;
                    n_slot  = w_slot_inc;
                    n_idx   = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_front <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_slot  <= '0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_slot  <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
    end

    dqis_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_in.value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // output queue: a finished word waits here while the next one is taken
    dqis_oreg u_oreg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_status (w_status),
        .i_data   (w_data),
        .o_room   (w_room),
        .o_out    (o_out)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_count))
        else $error("scan offset past live entries");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_full &&
         (i_in.mode == MODE_PUSH_FRONT || i_in.mode == MODE_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not grow the deque");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_room)
        else $error("result pushed into a full output queue");

endmodule

// ----- sim/deque_with_index_read_and_search_top_tb.sv -----
module deque_with_index_read_and_search_top_tb;
    import dqis_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CNT_W       = PTR_W + 1;
    localparam int RAND_WORDS  = 1900;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = DEPTH + 8;
    localparam int SHOW_LIMIT  = 10;
    // generous: roughly eight times the slowest legal run
    localparam int RUN_LIMIT   = 2000000;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // one result word as the block should produce it
    typedef struct packed {
        t_status                   status;
        logic signed [VALUE_W-1:0] data;
    } t_word_result;

    // Shadow deque plus the queue of results still owed by the block.
    // Slot arithmetic wraps by truncation, so DEPTH is a power of two.
    class deque_scoreboard;
        logic signed [VALUE_W-1:0] slots [DEPTH];
        logic [PTR_W-1:0]          head;
        logic [CNT_W-1:0]          fill;
        t_word_result              due_results [$];
        int                        failures;
        int                        results_seen;

        function new();
            head         = '0;
            fill         = '0;
            failures     = 0;
            results_seen = 0;
        endfunction

        function logic signed [VALUE_W-1:0] live_entry(int k);
            logic [PTR_W-1:0] idx;
            idx = head + k[PTR_W-1:0];
            return slots[idx];
        endfunction

        // work out what the block owes for one accepted input word
        function void note_word(t_mode mode, logic signed [VALUE_W-1:0] value,
                                logic [POS_W-1:0] position);
            t_word_result     res;
            logic [PTR_W-1:0] idx;
            bit               found;
            res.status = ST_OK;
            res.data   = '0;
            found      = 1'b0;
            case (mode)
                MODE_PUSH_FRONT: begin
                    if (fill == DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        head        = head - 1'b1;
                        slots[head] = value;
                        fill        = fill + 1'b1;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (fill == DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        idx        = head + fill[PTR_W-1:0];
                        slots[idx] = value;
                        fill       = fill + 1'b1;
                    end
                end
                MODE_READ: begin
                    if (fill == 0) begin
                        res.status = ST_EMPTY;
                    end else if (position >= fill) begin
                        res.status = ST_MISS;
                    end else begin
                        idx      = head + position[PTR_W-1:0];
                        res.data = slots[idx];
                    end
                end
                default: begin
                    if (fill == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        for (int k = 0; k < fill; k++) begin
                            if (!found && live_entry(k) == value) found = 1'b1;
                        end
                        res.status = found ? ST_OK : ST_MISS;
                        res.data   = found ? value : '0;
                    end
                end
            endcase
            due_results.push_back(res);
        endfunction

        // compare one result word with the oldest one owed
        function void check_word(logic [STATUS_W-1:0] status, logic signed [VALUE_W-1:0] data);
            t_word_result want;
            results_seen++;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("result word %0d unexpected: status %0d data %0d",
                             results_seen, status, data);
                return;
            end
            want = due_results.pop_front();
            if (status !== want.status || data !== want.data) begin
                failures++;
                if (failures <= SHOW_LIMIT)
                    $display("result word %0d: expected status %s data %0d, got status %0d data %0d",
                             results_seen, want.status.name(), want.data, status, data);
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    dqis_in_if  word_in_ch ();
    dqis_out_if word_out_ch ();

    deque_with_index_read_and_search_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_in_ch),
        .o_out   (word_out_ch)
    );

    deque_scoreboard sb;

    // long receiver hold-offs asked by the sender side, served by the receiver
    int holds_asked;
    int holds_served;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung block ends the run as a failure.
    initial begin
        #(RUN_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Monitor: both channels sampled at the rising edge, i.e. pre-edge values.
    // Input noted before output is checked, though latency keeps them apart anyway.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (word_in_ch.valid && word_in_ch.ready)
                sb.note_word(t_mode'(word_in_ch.mode), word_in_ch.value, word_in_ch.position);
            if (word_out_ch.valid && word_out_ch.ready)
                sb.check_word(word_out_ch.status, word_out_ch.data_out);
        end
    end

    // Receiver: ready changes at the falling edge following a pattern that
    // switches style after each window of random length; a requested hold-off
    // keeps ready low so the block backs up and stalls its input.
    initial begin : rx_side
        int style;
        int window;
        int phase_ctr;
        style             = 0;
        window            = 0;
        phase_ctr         = 0;
        word_out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_served != holds_asked) begin
                word_out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_served++;
            end
            if (window == 0) begin
                style  = $urandom_range(0, 3);
                window = $urandom_range(8, 64);
            end
            window--;
            phase_ctr++;
            case (style)
                0:       word_out_ch.ready = 1'b1;
                1:       word_out_ch.ready = 1'($urandom_range(0, 1));
                2:       word_out_ch.ready = (phase_ctr % 4 == 0);
                default: word_out_ch.ready = ($urandom_range(0, 6) != 0);
            endcase
        end
    end

    // hold the current word until the block takes it
    task automatic wait_taken();
        do @(posedge i_clk); while (!(word_in_ch.valid && word_in_ch.ready));
    endtask

    task automatic offer_word(t_mode m, logic signed [VALUE_W-1:0] v, logic [POS_W-1:0] p);
        @(negedge i_clk);
        word_in_ch.valid    = 1'b1;
        word_in_ch.mode     = m;
        word_in_ch.value    = v;
        word_in_ch.position = p;
        wait_taken();
    endtask

    // sender idle: valid low, payload wiggles as noise
    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            word_in_ch.valid    = 1'b0;
            word_in_ch.mode     = MODE_W'($urandom);
            word_in_ch.value    = $urandom;
            word_in_ch.position = POS_W'($urandom);
        end
    endtask

    // sender stops until every owed result has come back
    task automatic drain_results();
        @(negedge i_clk);
        word_in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Random word, chosen at the falling edge so the shadow state is current.
    // Pushes are rare enough that the deque fills over a hundred or so words;
    // finds mostly hit live entries, some near misses with one bit flipped.
    task automatic offer_random_word();
        int                        r;
        int                        fill_now;
        t_mode                     m;
        logic signed [VALUE_W-1:0] v;
        logic [POS_W-1:0]          p;
        @(negedge i_clk);
        fill_now = int'(sb.fill);
        r        = $urandom_range(0, 99);
        v        = $urandom;
        p        = POS_W'($urandom);
        if (r < 6)       m = MODE_PUSH_FRONT;
        else if (r < 12) m = MODE_PUSH_BACK;
        else if (r < 50) m = MODE_READ;
        else             m = MODE_FIND;
        r = $urandom_range(0, 99);
        case (m)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                if (r < 15) begin
                    case ($urandom_range(0, 3))
                        0:       v = VAL_MIN;
                        1:       v = VAL_MAX;
                        2:       v = '0;
                        default: v = -1;
                    endcase
                end else if (r < 30 && fill_now > 0) begin
                    v = sb.live_entry($urandom_range(0, fill_now - 1));
                end
            end
            MODE_READ: begin
                if (r < 70) p = POS_W'($urandom_range(0, fill_now + 1));
            end
            default: begin
                if (fill_now > 0 && r < 55) begin
                    v = sb.live_entry($urandom_range(0, fill_now - 1));
                end else if (fill_now > 0 && r < 65) begin
                    v = sb.live_entry($urandom_range(0, fill_now - 1));
                    v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
                end
            end
        endcase
        word_in_ch.valid    = 1'b1;
        word_in_ch.mode     = m;
        word_in_ch.value    = v;
        word_in_ch.position = p;
        wait_taken();
    endtask

    initial begin : stimulus
        int burst_left;
        sb                  = new();
        holds_asked         = 0;
        holds_served        = 0;
        burst_left          = 0;
        i_rst_n             = 1'b0;
        word_in_ch.valid    = 1'b0;
        word_in_ch.mode     = MODE_PUSH_FRONT;
        word_in_ch.value    = '0;
        word_in_ch.position = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: empty deque first, then extremes pushed at both ends,
        // reads at the front, the back and past the end, and finds that hit
        // the middle, the last entry, and nothing.
        offer_word(MODE_READ,       '0,      8'd0);
        offer_word(MODE_FIND,       '0,      8'd0);
        offer_word(MODE_PUSH_FRONT, VAL_MIN, 8'd0);
        offer_word(MODE_PUSH_BACK,  VAL_MAX, 8'd0);
        offer_word(MODE_PUSH_FRONT, '0,      8'd0);
        offer_word(MODE_PUSH_BACK,  -1,      8'd0);
        offer_word(MODE_PUSH_FRONT, 1,       8'd0);
        offer_word(MODE_READ,       '0,      8'd0);
        offer_word(MODE_READ,       '0,      8'd4);
        offer_word(MODE_READ,       '0,      8'd5);
        offer_word(MODE_READ,       '0,      8'd255);
        offer_word(MODE_FIND,       VAL_MIN, 8'd0);
        offer_word(MODE_FIND,       -1,      8'd0);
        offer_word(MODE_FIND,       2,       8'd0);
        offer_word(MODE_FIND,       VAL_MAX, 8'd0);
        offer_word(MODE_PUSH_BACK,  32'sh5555_5555, 8'd0);
        offer_word(MODE_PUSH_FRONT, 32'shAAAA_AAAA, 8'd0);
        offer_word(MODE_READ,       '0,      8'd6);
        drain_results();

        // Random part: bursts of words with random gaps, some back to back.
        for (int n = 0; n < RAND_WORDS; n++) begin
            if (n == 500) holds_asked++;          // receiver backs off, sender keeps going
            if (n == 1200) drain_results();       // sender pauses until all results are in
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
            end
            burst_left--;
            offer_random_word();
        end

        drain_results();
        // keep the clock running to catch any stray result word
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
